FILE: rtl/core/esutc_pkg.sv
`default_nettype none

package esutc_pkg;

  // Port widths.
  localparam int EpochWidth  = 41;
  localparam int YearWidth   = 16;
  localparam int MonthWidth  = 4;
  localparam int DayWidth    = 5;
  localparam int HourWidth   = 5;
  localparam int MinSecWidth = 6;

  // Number of valid bits from the input register to the result register.
  localparam int PipeDepth = 11;

  // Internal value widths.
  localparam int DaysWidth = 24;  // whole days, and days shifted to the March origin
  localparam int SodWidth  = 17;  // second of day
  localparam int EraWidth  = 7;   // 400-year eras since year 0
  localparam int DoeWidth  = 18;  // day of era
  localparam int YoeWidth  = 9;   // year of era
  localparam int DoyWidth  = 9;   // day of a March-based year
  localparam int RemWidth  = 12;  // second of hour

  // Calendar constants.
  localparam int SecsPerDay = 86400;
  localparam int DaysShift  = 719468;
  localparam int EraDays    = 146097;
  localparam int CentDays   = 36524;
  localparam int SecsPerHr  = 3600;

  // 86400 is 675 shifted left by 7, so the day split divides the upper bits by 675.
  localparam int SecSplit  = 7;
  localparam int SecHiW    = EpochWidth - 1 - SecSplit;
  localparam int SecDiv    = SecsPerDay >> SecSplit;
  localparam int DayShift  = SecHiW + 10;
  localparam logic [63:0] DayRecipFull =
    ((64'd1 << DayShift) + 64'(SecDiv - 1)) / 64'(SecDiv);
  localparam int DayRecipW = 34;
  localparam int DayRecipSplit = DayRecipW / 2;
  localparam logic [DayRecipSplit-1:0] DayRecipLo = DayRecipFull[DayRecipSplit-1:0];
  localparam logic [DayRecipSplit-1:0] DayRecipHi =
    DayRecipFull[DayRecipW-1:DayRecipSplit];

  // Day count to era: 24-bit dividend, divisor below 2**18.
  localparam int EraShift = 42;
  localparam logic [63:0] EraRecipFull =
    ((64'd1 << EraShift) + 64'(EraDays - 1)) / 64'(EraDays);
  localparam logic [24:0] EraRecip = EraRecipFull[24:0];

  // Second of day to hour: (sod >> 4) / 225.
  localparam int HourShift = 21;
  localparam logic [63:0] HourRecipFull = ((64'd1 << HourShift) + 64'd224) / 64'd225;
  localparam logic [13:0] HourRecip = HourRecipFull[13:0];

  // Second of hour to minute: (rem >> 2) / 15.
  localparam int MinShift = 14;
  localparam logic [63:0] MinRecipFull = ((64'd1 << MinShift) + 64'd14) / 64'd15;
  localparam logic [10:0] MinRecip = MinRecipFull[10:0];

  // Day of era over 1460: (doe >> 2) / 365.
  localparam int QuadShift = 25;
  localparam logic [63:0] QuadRecipFull = ((64'd1 << QuadShift) + 64'd364) / 64'd365;
  localparam logic [16:0] QuadRecip = QuadRecipFull[16:0];

  // Corrected day of era over 365.
  localparam int YearShift = 27;
  localparam logic [63:0] YearRecipFull = ((64'd1 << YearShift) + 64'd364) / 64'd365;
  localparam logic [18:0] YearRecip = YearRecipFull[18:0];

  // (5 * doy + 2) / 153.
  localparam int MonShift = 19;
  localparam logic [63:0] MonRecipFull = ((64'd1 << MonShift) + 64'd152) / 64'd153;
  localparam logic [11:0] MonRecip = MonRecipFull[11:0];

endpackage

`default_nettype wire

FILE: rtl/core/epoch_seconds_to_utc_datetime.sv
// Epoch seconds to UTC calendar date and time of day.
//
// The input channel takes one signed count of seconds since 1970-01-01 UTC.
// An item is taken at a rising clock edge where start_i is high and busy_o is
// low. busy_o is high only during reset and until the clock edge after it, so
// from then on an item can be taken in every cycle.
//
// Each item gives one result item: year, month, day, hour, minute and second,
// shown for one cycle with done_o high. The result for an item passes through
// the input register, stages 1 to 9 and the result register. Results leave in
// the order the items came in. A negative count gives a result of all zeros.
//
// The work runs through a fixed pipeline of eleven register stages: every
// division by a calendar constant is a multiply by a reciprocal, and most
// quotients feed the subtraction in the next stage. The throughput is one
// item per cycle.
//
// The receiver cannot stall; done_o is a one-cycle strobe. Reset clears the
// valid bits, so no result is shown for items caught in flight.

`default_nettype none

module epoch_seconds_to_utc_datetime
  import esutc_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic signed [EpochWidth-1:0] seconds_since_epoch_i,
  output logic                         done_o,
  output logic [YearWidth-1:0]         cal_year_o,
  output logic [MonthWidth-1:0]        cal_month_o,
  output logic [DayWidth-1:0]          day_of_month_o,
  output logic [HourWidth-1:0]         hour_of_day_o,
  output logic [MinSecWidth-1:0]       minute_of_hour_o,
  output logic [MinSecWidth-1:0]       second_of_minute_o
);

  // Start of each March-based month, in days from March 1.
  function automatic logic [DoyWidth-1:0] month_start(input logic [3:0] mp);
    logic [DoyWidth-1:0] res;
    case (mp)
      4'd0:    res = 9'd0;
      4'd1:    res = 9'd31;
      4'd2:    res = 9'd61;
      4'd3:    res = 9'd92;
      4'd4:    res = 9'd122;
      4'd5:    res = 9'd153;
      4'd6:    res = 9'd184;
      4'd7:    res = 9'd214;
      4'd8:    res = 9'd245;
      4'd9:    res = 9'd275;
      4'd10:   res = 9'd306;
      4'd11:   res = 9'd337;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

  localparam int PlW = SecHiW + DayRecipSplit;

  // Control.
  logic                 busy_q;
  logic [PipeDepth-1:0] vld_q, vld_d;
  logic                 accept;

  // Stage 0: input register.
  logic [EpochWidth-1:0] x_q;

  // Stage 1: partial products of the day split.
  logic                      s1_neg_q;
  logic [9:0]                s1_alow_q;
  logic [SecSplit-1:0]       s1_lo_q;
  logic [PlW-1:0]            s1_pl_q, s1_pl_d;
  logic [PlW-1:0]            s1_ph_q, s1_ph_d;

  // Stage 2: whole days.
  logic                 s2_neg_q;
  logic [9:0]           s2_alow_q;
  logic [SecSplit-1:0]  s2_lo_q;
  logic [DaysWidth-1:0] s2_days_q, s2_days_d;
  logic [66:0]          day_prod;

  // Stage 3: second of day and shifted day count.
  logic                 s3_neg_q;
  logic [SodWidth-1:0]  s3_sod_q, s3_sod_d;
  logic [DaysWidth-1:0] s3_z_q, s3_z_d;
  logic [33:0]          days_x675;

  // Stage 4: era and hour.
  logic                 s4_neg_q;
  logic [SodWidth-1:0]  s4_sod_q;
  logic [DaysWidth-1:0] s4_z_q;
  logic [EraWidth-1:0]  s4_era_q, s4_era_d;
  logic [HourWidth-1:0] s4_hour_q, s4_hour_d;
  logic [48:0]          era_prod;
  logic [26:0]          hour_prod;

  // Stage 5: day of era and second of hour.
  logic                 s5_neg_q;
  logic [EraWidth-1:0]  s5_era_q;
  logic [HourWidth-1:0] s5_hour_q;
  logic [DoeWidth-1:0]  s5_doe_q, s5_doe_d;
  logic [RemWidth-1:0]  s5_rem_q, s5_rem_d;
  logic [24:0]          era_days;
  logic [16:0]          hour_secs;

  // Stage 6: leap-corrected day of era and minute.
  logic                   s6_neg_q;
  logic [EraWidth-1:0]    s6_era_q;
  logic [HourWidth-1:0]   s6_hour_q;
  logic [DoeWidth-1:0]    s6_doe_q;
  logic [RemWidth-1:0]    s6_rem_q;
  logic [DoeWidth-1:0]    s6_t_q, s6_t_d;
  logic [MinSecWidth-1:0] s6_min_q, s6_min_d;
  logic [32:0]            quad_prod;
  logic [6:0]             quads;
  logic [2:0]             cents;
  logic                   last_day;
  logic [20:0]            min_prod;

  // Stage 7: year of era and second.
  logic                   s7_neg_q;
  logic [EraWidth-1:0]    s7_era_q;
  logic [HourWidth-1:0]   s7_hour_q;
  logic [MinSecWidth-1:0] s7_min_q;
  logic [DoeWidth-1:0]    s7_doe_q;
  logic [YoeWidth-1:0]    s7_yoe_q, s7_yoe_d;
  logic [MinSecWidth-1:0] s7_sec_q, s7_sec_d;
  logic [36:0]            yoe_prod;
  logic [11:0]            min_secs;

  // Stage 8: day of year.
  logic                   s8_neg_q;
  logic [EraWidth-1:0]    s8_era_q;
  logic [HourWidth-1:0]   s8_hour_q;
  logic [MinSecWidth-1:0] s8_min_q;
  logic [MinSecWidth-1:0] s8_sec_q;
  logic [YoeWidth-1:0]    s8_yoe_q;
  logic [DoyWidth-1:0]    s8_doy_q, s8_doy_d;
  logic [1:0]             yoe_cents;
  logic [DoeWidth-1:0]    year_days;

  // Stage 9: March-based month.
  logic                   s9_neg_q;
  logic [EraWidth-1:0]    s9_era_q;
  logic [HourWidth-1:0]   s9_hour_q;
  logic [MinSecWidth-1:0] s9_min_q;
  logic [MinSecWidth-1:0] s9_sec_q;
  logic [YoeWidth-1:0]    s9_yoe_q;
  logic [DoyWidth-1:0]    s9_doy_q;
  logic [3:0]             s9_mp_q, s9_mp_d;
  logic [10:0]            mp_arg;
  logic [22:0]            mp_prod;

  // Stage 10: result register.
  logic [YearWidth-1:0]   year_q, year_d;
  logic [MonthWidth-1:0]  month_q, month_d;
  logic [DayWidth-1:0]    day_q, day_d;
  logic [HourWidth-1:0]   hour_q, hour_d;
  logic [MinSecWidth-1:0] min_q, min_d;
  logic [MinSecWidth-1:0] sec_q, sec_d;
  logic [DoyWidth-1:0]    dom;
  logic [3:0]             month_calc;
  logic                   jan_feb;

  assign accept = start_i && !busy_q;
  assign vld_d  = {vld_q[PipeDepth-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      vld_q  <= '0;
    end else begin
      busy_q <= 1'b0;
      vld_q  <= vld_d;
    end
  end

  always_comb begin
    // Stage 1: split the upper seconds over the two halves of the reciprocal of 675.
    s1_pl_d = PlW'(x_q[EpochWidth-2:SecSplit]) * PlW'(DayRecipLo);
    s1_ph_d = PlW'(x_q[EpochWidth-2:SecSplit]) * PlW'(DayRecipHi);

    // Stage 2: recombine; the quotient is the whole-day count.
    day_prod  = (67'(s1_ph_q) << DayRecipSplit) + 67'(s1_pl_q);
    s2_days_d = day_prod[DayShift +: DaysWidth];

    // Stage 3: the remainder by 675 stays below 1024, so ten bits carry it.
    days_x675 = 34'(s2_days_q) * 34'(SecDiv);
    s3_sod_d  = {s2_alow_q - days_x675[9:0], s2_lo_q};
    s3_z_d    = s2_days_q + DaysWidth'(DaysShift);

    // Stage 4.
    era_prod  = 49'(s3_z_q) * 49'(EraRecip);
    s4_era_d  = era_prod[EraShift +: EraWidth];
    hour_prod = 27'(s3_sod_q[SodWidth-1:4]) * 27'(HourRecip);
    s4_hour_d = hour_prod[HourShift +: HourWidth];

    // Stage 5.
    era_days  = 25'(s4_era_q) * 25'(EraDays);
    s5_doe_d  = s4_z_q[DoeWidth-1:0] - era_days[DoeWidth-1:0];
    hour_secs = 17'(s4_hour_q) * 17'(SecsPerHr);
    s5_rem_d  = s4_sod_q[RemWidth-1:0] - hour_secs[RemWidth-1:0];

    // Stage 6: remove the leap days so that every year of the era has 365 days.
    quad_prod = 33'(s5_doe_q[DoeWidth-1:2]) * 33'(QuadRecip);
    quads     = quad_prod[QuadShift +: 7];
    cents     = 3'(s5_doe_q >= DoeWidth'(CentDays)) +
                3'(s5_doe_q >= DoeWidth'(2 * CentDays)) +
                3'(s5_doe_q >= DoeWidth'(3 * CentDays)) +
                3'(s5_doe_q >= DoeWidth'(4 * CentDays));
    last_day  = (s5_doe_q == DoeWidth'(EraDays - 1));
    s6_t_d    = s5_doe_q - DoeWidth'(quads) + DoeWidth'(cents) - DoeWidth'(last_day);
    min_prod  = 21'(s5_rem_q[RemWidth-1:2]) * 21'(MinRecip);
    s6_min_d  = min_prod[MinShift +: MinSecWidth];

    // Stage 7.
    yoe_prod  = 37'(s6_t_q) * 37'(YearRecip);
    s7_yoe_d  = yoe_prod[YearShift +: YoeWidth];
    min_secs  = 12'(s6_min_q) * 12'd60;
    s7_sec_d  = s6_rem_q[MinSecWidth-1:0] - min_secs[MinSecWidth-1:0];

    // Stage 8: days before this year within the era.
    yoe_cents = 2'(s7_yoe_q >= 9'd100) + 2'(s7_yoe_q >= 9'd200) + 2'(s7_yoe_q >= 9'd300);
    year_days = DoeWidth'(s7_yoe_q) * DoeWidth'(365) + DoeWidth'(s7_yoe_q[YoeWidth-1:2])
                - DoeWidth'(yoe_cents);
    s8_doy_d  = s7_doe_q[DoyWidth-1:0] - year_days[DoyWidth-1:0];

    // Stage 9.
    mp_arg  = 11'(s8_doy_q) * 11'd5 + 11'd2;
    mp_prod = 23'(mp_arg) * 23'(MonRecip);
    s9_mp_d = mp_prod[MonShift +: 4];

    // Stage 10: the year starts in March, so January and February belong to the next one.
    dom        = s9_doy_q - month_start(s9_mp_q) + 9'd1;
    jan_feb    = (s9_mp_q >= 4'd10);
    month_calc = jan_feb ? s9_mp_q - 4'd9 : s9_mp_q + 4'd3;
    if (s9_neg_q) begin
      year_d  = '0;
      month_d = '0;
      day_d   = '0;
      hour_d  = '0;
      min_d   = '0;
      sec_d   = '0;
    end else begin
      year_d  = YearWidth'(s9_yoe_q) + YearWidth'(s9_era_q) * YearWidth'(400)
                + YearWidth'(jan_feb);
      month_d = month_calc;
      day_d   = dom[DayWidth-1:0];
      hour_d  = s9_hour_q;
      min_d   = s9_min_q;
      sec_d   = s9_sec_q;
    end
  end

  // Payload registers; the valid bits above say which stages hold an item.
  always_ff @(posedge clk_i) begin
    x_q <= $unsigned(seconds_since_epoch_i);

    s1_neg_q  <= x_q[EpochWidth-1];
    s1_alow_q <= x_q[SecSplit +: 10];
    s1_lo_q   <= x_q[SecSplit-1:0];
    s1_pl_q   <= s1_pl_d;
    s1_ph_q   <= s1_ph_d;

    s2_neg_q  <= s1_neg_q;
    s2_alow_q <= s1_alow_q;
    s2_lo_q   <= s1_lo_q;
    s2_days_q <= s2_days_d;

    s3_neg_q <= s2_neg_q;
    s3_sod_q <= s3_sod_d;
    s3_z_q   <= s3_z_d;

    s4_neg_q  <= s3_neg_q;
    s4_sod_q  <= s3_sod_q;
    s4_z_q    <= s3_z_q;
    s4_era_q  <= s4_era_d;
    s4_hour_q <= s4_hour_d;

    s5_neg_q  <= s4_neg_q;
    s5_era_q  <= s4_era_q;
    s5_hour_q <= s4_hour_q;
    s5_doe_q  <= s5_doe_d;
    s5_rem_q  <= s5_rem_d;

    s6_neg_q  <= s5_neg_q;
    s6_era_q  <= s5_era_q;
    s6_hour_q <= s5_hour_q;
    s6_doe_q  <= s5_doe_q;
    s6_rem_q  <= s5_rem_q;
    s6_t_q    <= s6_t_d;
    s6_min_q  <= s6_min_d;

    s7_neg_q  <= s6_neg_q;
    s7_era_q  <= s6_era_q;
    s7_hour_q <= s6_hour_q;
    s7_min_q  <= s6_min_q;
    s7_doe_q  <= s6_doe_q;
    s7_yoe_q  <= s7_yoe_d;
    s7_sec_q  <= s7_sec_d;

    s8_neg_q  <= s7_neg_q;
    s8_era_q  <= s7_era_q;
    s8_hour_q <= s7_hour_q;
    s8_min_q  <= s7_min_q;
    s8_sec_q  <= s7_sec_q;
    s8_yoe_q  <= s7_yoe_q;
    s8_doy_q  <= s8_doy_d;

    s9_neg_q  <= s8_neg_q;
    s9_era_q  <= s8_era_q;
    s9_hour_q <= s8_hour_q;
    s9_min_q  <= s8_min_q;
    s9_sec_q  <= s8_sec_q;
    s9_yoe_q  <= s8_yoe_q;
    s9_doy_q  <= s8_doy_q;
    s9_mp_q   <= s9_mp_d;

    year_q  <= year_d;
    month_q <= month_d;
    day_q   <= day_d;
    hour_q  <= hour_d;
    min_q   <= min_d;
    sec_q   <= sec_d;
  end

  assign busy_o             = busy_q;
  assign done_o             = vld_q[PipeDepth-1];
  assign cal_year_o         = year_q;
  assign cal_month_o        = month_q;
  assign day_of_month_o     = day_q;
  assign hour_of_day_o      = hour_q;
  assign minute_of_hour_o   = min_q;
  assign second_of_minute_o = sec_q;

endmodule

`default_nettype wire

FILE: rtl/core/esutc_checker.sv
`default_nettype none

module esutc_checker
  import esutc_pkg::*;
(
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start_i,
  input logic                         busy_o,
  input logic signed [EpochWidth-1:0] seconds_since_epoch_i,
  input logic                         done_o,
  input logic [YearWidth-1:0]         cal_year_o,
  input logic [MonthWidth-1:0]        cal_month_o,
  input logic [DayWidth-1:0]          day_of_month_o,
  input logic [HourWidth-1:0]         hour_of_day_o,
  input logic [MinSecWidth-1:0]       minute_of_hour_o,
  input logic [MinSecWidth-1:0]       second_of_minute_o
);

  // Every item taken gives its result.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##PipeDepth done_o)
    else $error("no result for an item taken");

  // No result appears without an item taken at the matching edge.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, PipeDepth))
    else $error("result without an item");

  // A negative count gives an all-zero result.
  a_negative_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && seconds_since_epoch_i[EpochWidth-1]) |-> ##PipeDepth
    (cal_year_o == '0 && cal_month_o == '0 && day_of_month_o == '0 &&
     hour_of_day_o == '0 && minute_of_hour_o == '0 && second_of_minute_o == '0))
    else $error("negative count gave a nonzero result");

  // A real date has fields in calendar range.
  a_fields_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && cal_month_o != '0) |->
    (cal_month_o <= 4'd12 && day_of_month_o != '0 && hour_of_day_o <= 5'd23 &&
     minute_of_hour_o <= 6'd59 && second_of_minute_o <= 6'd59))
    else $error("result field out of range");

endmodule

bind epoch_seconds_to_utc_datetime esutc_checker u_esutc_checker (.*);

`default_nettype wire

FILE: bench/epoch_seconds_to_utc_datetime_test.sv
`timescale 1ns / 100ps

module epoch_seconds_to_utc_datetime_test;
  import esutc_pkg::*;

  // Run length and guard limits.
  localparam int RandomItems   = 530;
  localparam int MaxGap        = 12;
  localparam int WatchdogLimit = 500;
  localparam int ResetCycles   = 12;

  // The largest count of seconds that is still positive at the input width,
  // and the last whole day that it reaches.
  localparam longint unsigned LastSecond = (64'd1 << (EpochWidth - 1)) - 1;
  localparam longint unsigned LastDay    = LastSecond / SecsPerDay;

  // One result item, field by field, at the widths of the result ports.
  typedef struct {
    logic [YearWidth-1:0]   year;
    logic [MonthWidth-1:0]  month;
    logic [DayWidth-1:0]    day;
    logic [HourWidth-1:0]   hour;
    logic [MinSecWidth-1:0] minute;
    logic [MinSecWidth-1:0] second;
  } utc_fields_t;

  // One row of the directed table. Where known_answer is set, the date in the
  // row is the answer; otherwise the answer comes from the calendar predictor.
  typedef struct {
    logic signed [EpochWidth-1:0] secs;
    bit                           known_answer;
    utc_fields_t                  answer;
  } directed_row_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         start_i;
  logic                         busy_o;
  logic signed [EpochWidth-1:0] seconds_since_epoch_i;
  logic                         done_o;
  logic [YearWidth-1:0]         cal_year_o;
  logic [MonthWidth-1:0]        cal_month_o;
  logic [DayWidth-1:0]          day_of_month_o;
  logic [HourWidth-1:0]         hour_of_day_o;
  logic [MinSecWidth-1:0]       minute_of_hour_o;
  logic [MinSecWidth-1:0]       second_of_minute_o;

  // Dates of the items that were taken and whose results have not come yet,
  // oldest first.
  utc_fields_t   dates_in_flight[$];
  directed_row_t directed_rows[$];

  // The answer that goes with the item now on the input ports.
  bit            item_known;
  utc_fields_t   item_answer;

  bit            no_gaps;
  int            error_count;
  int            quiet_cycles;

  epoch_seconds_to_utc_datetime dut (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .seconds_since_epoch_i,
    .done_o,
    .cal_year_o,
    .cal_month_o,
    .day_of_month_o,
    .hour_of_day_o,
    .minute_of_hour_o,
    .second_of_minute_o
  );

  initial clk_i = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Calendar predictor. The seconds are split into whole days and a second of
  // day. The days are moved to a 0000-03-01 origin so that the leap day falls
  // at the end of each year, split into 400-year eras, and each era is taken
  // apart into a year, a day of that year and a month that starts in March.
  // January and February then belong to the following civil year. A negative
  // count has no date and gives all zeros.
  function automatic utc_fields_t civil_time_of(input logic signed [EpochWidth-1:0] secs);
    longint unsigned count;
    longint unsigned day_count;
    longint unsigned second_of_day;
    longint unsigned shifted_days;
    longint unsigned era;
    longint unsigned day_of_era;
    longint unsigned year_of_era;
    longint unsigned day_of_year;
    longint unsigned march_month;
    longint unsigned civil_month;
    longint unsigned civil_year;
    utc_fields_t     date;

    date = '{default: '0};
    if (secs[EpochWidth-1]) begin
      return date;
    end

    count         = longint'(secs);
    day_count     = count / SecsPerDay;
    second_of_day = count % SecsPerDay;

    shifted_days = day_count + DaysShift;
    era          = shifted_days / EraDays;
    day_of_era   = shifted_days - era * EraDays;
    // Leap days of the four-year, century and era cycles are taken out
    // before the division by the length of a common year.
    year_of_era  = (day_of_era - day_of_era / 1460 + day_of_era / CentDays
                    - day_of_era / 146096) / 365;
    day_of_year  = day_of_era - (365 * year_of_era + year_of_era / 4 - year_of_era / 100);
    march_month  = (5 * day_of_year + 2) / 153;
    civil_month  = (march_month < 10) ? march_month + 3 : march_month - 9;
    civil_year   = year_of_era + era * 400;
    if (civil_month <= 2) begin
      civil_year = civil_year + 1;
    end

    date.year   = civil_year[YearWidth-1:0];
    date.month  = civil_month[MonthWidth-1:0];
    date.day    = 5'(day_of_year - (153 * march_month + 2) / 5 + 1);
    date.hour   = 5'(second_of_day / SecsPerHr);
    date.minute = 6'((second_of_day % SecsPerHr) / 60);
    date.second = 6'(second_of_day % 60);
    return date;
  endfunction

  task automatic add_row(input logic signed [EpochWidth-1:0] secs, input bit known,
                         input int year, input int month, input int day,
                         input int hour, input int minute, input int second);
    directed_row_t row;

    row.secs          = secs;
    row.known_answer  = known;
    row.answer.year   = YearWidth'(year);
    row.answer.month  = MonthWidth'(month);
    row.answer.day    = DayWidth'(day);
    row.answer.hour   = HourWidth'(hour);
    row.answer.minute = MinSecWidth'(minute);
    row.answer.second = MinSecWidth'(second);
    directed_rows.push_back(row);
  endtask

  task automatic compare_field(input string field, input longint unsigned want,
                               input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      error_count++;
    end
  endtask

  // Random seconds, shaped to reach deep into the calendar. A share covers
  // the whole input word, so every bit and both signs are seen. Most items
  // are positive: spread over the whole range, right around a midnight where
  // day, month and year roll over, or anywhere within the first few centuries
  // so that leap years and the skipped century leap days come up often.
  function automatic logic signed [EpochWidth-1:0] pick_seconds();
    longint unsigned raw;
    longint unsigned day_count;
    int unsigned     kind;

    kind = $urandom_range(0, 99);
    raw  = {$urandom, $urandom};
    if (kind < 20) begin
      raw = raw;
    end else if (kind < 55) begin
      raw = raw & LastSecond;
    end else if (kind < 80) begin
      day_count = $urandom_range(0, int'(LastDay));
      // The offset may step below zero on the first day, which makes a
      // negative count just under the epoch.
      raw = day_count * SecsPerDay + $urandom_range(0, 4) - 2;
    end else begin
      day_count = $urandom_range(0, 200000);
      raw = day_count * SecsPerDay + $urandom_range(0, SecsPerDay - 1);
    end
    return raw[EpochWidth-1:0];
  endfunction

  // Hands one item to the block. Each call is entered at a falling edge and
  // returns at the falling edge after the item was taken, so start_i stays
  // high from one item to the next when there is no gap.
  task automatic send_item(input logic signed [EpochWidth-1:0] secs, input bit known,
                           input utc_fields_t answer);
    int unsigned gap;

    gap = no_gaps ? 0 : $urandom_range(0, MaxGap);
    if (gap > 0) begin
      start_i               <= 1'b0;
      seconds_since_epoch_i <= EpochWidth'({$urandom, $urandom});
      repeat (gap) @(negedge clk_i);
    end
    item_known            = known;
    item_answer           = answer;
    start_i               <= 1'b1;
    seconds_since_epoch_i <= secs;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
  endtask

  // Holds the input off until every date in flight has come out.
  task automatic drain_pipe();
    start_i <= 1'b0;
    do @(negedge clk_i); while (dates_in_flight.size() != 0);
  endtask

  // Result checker and watchdog. Inputs change only at the falling edge, so
  // at the rising edge both the handshake and the result ports are settled.
  always @(posedge clk_i) begin : result_check
    utc_fields_t got;
    utc_fields_t want;
    bit          taken;

    taken = rst_ni && start_i && !busy_o;
    if (done_o) begin
      got = '{cal_year_o, cal_month_o, day_of_month_o,
              hour_of_day_o, minute_of_hour_o, second_of_minute_o};
      if (dates_in_flight.size() == 0) begin
        $display("%0t: result with no item in flight, actual %0d-%0d-%0d %0d:%0d:%0d",
                 $time, got.year, got.month, got.day, got.hour, got.minute, got.second);
        error_count++;
      end else begin
        want = dates_in_flight.pop_front();
        compare_field("cal_year", want.year, got.year);
        compare_field("cal_month", want.month, got.month);
        compare_field("day_of_month", want.day, got.day);
        compare_field("hour_of_day", want.hour, got.hour);
        compare_field("minute_of_hour", want.minute, got.minute);
        compare_field("second_of_minute", want.second, got.second);
      end
    end
    if (taken) begin
      dates_in_flight.push_back(item_known ? item_answer
                                           : civil_time_of(seconds_since_epoch_i));
    end

    // The watchdog counts cycles in which neither an item nor a result
    // moves; a hung block ends the run here.
    if (taken || done_o) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    utc_fields_t no_date;

    no_date               = '{default: '0};
    error_count           = 0;
    quiet_cycles          = 0;
    no_gaps               = 1'b0;
    item_known            = 1'b0;
    item_answer           = no_date;
    rst_ni                = 1'b0;
    start_i               = 1'b0;
    seconds_since_epoch_i = '0;

    // Directed table. Dates are written in where they are plain to see; the
    // rest are worked out by the predictor.
    add_row(0, 1, 1970, 1, 1, 0, 0, 0);                  // the epoch itself
    add_row(1, 1, 1970, 1, 1, 0, 0, 1);
    add_row(59, 1, 1970, 1, 1, 0, 0, 59);                // last second of a minute
    add_row(3599, 1, 1970, 1, 1, 0, 59, 59);             // last second of an hour
    add_row(86399, 1, 1970, 1, 1, 23, 59, 59);           // last second of a day
    add_row(86400, 1, 1970, 1, 2, 0, 0, 0);
    add_row(-1, 1, 0, 0, 0, 0, 0, 0);                    // just before the epoch
    add_row(-86400, 1, 0, 0, 0, 0, 0, 0);
    add_row({1'b1, {(EpochWidth - 1){1'b0}}}, 1, 0, 0, 0, 0, 0, 0);  // most negative
    add_row(31535999, 1, 1970, 12, 31, 23, 59, 59);      // end of the first year
    add_row(31536000, 1, 1971, 1, 1, 0, 0, 0);
    add_row(946684800, 1, 2000, 1, 1, 0, 0, 0);
    add_row(2147483647, 1, 2038, 1, 19, 3, 14, 7);       // top of a 32-bit count
    add_row(68169600, 0, 0, 0, 0, 0, 0, 0);              // leap day of 1972
    add_row(951782400, 0, 0, 0, 0, 0, 0, 0);             // leap day of an era year
    add_row(951868800, 0, 0, 0, 0, 0, 0, 0);
    add_row(EpochWidth'(64'sd4107456000), 0, 0, 0, 0, 0, 0, 0);  // 2100 has no leap day
    add_row(EpochWidth'(64'sd4107542400), 0, 0, 0, 0, 0, 0, 0);
    add_row(EpochWidth'(64'sd13574563200), 0, 0, 0, 0, 0, 0, 0);
    add_row({2'b01, {(EpochWidth - 2){1'b0}}}, 0, 0, 0, 0, 0, 0, 0);
    // Last whole days of the range.
    add_row(EpochWidth'(64'sd1099511540000), 0, 0, 0, 0, 0, 0, 0);
    add_row({1'b0, {(EpochWidth - 1){1'b1}}}, 0, 0, 0, 0, 0, 0, 0);  // most positive

    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].secs, directed_rows[i].known_answer,
                directed_rows[i].answer);
    end

    // Let the pipeline run dry once before the random part.
    drain_pipe();

    for (int n = 0; n < RandomItems; n++) begin
      // Every so often switch between random gaps and a back-to-back burst.
      if (n % 32 == 0) begin
        no_gaps = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 59) == 0) begin
        drain_pipe();
      end
      send_item(pick_seconds(), 1'b0, no_date);
    end

    start_i <= 1'b0;
    while (dates_in_flight.size() != 0) @(posedge clk_i);
    // Watch a little longer for any stray result.
    repeat (PipeDepth + 4) @(posedge clk_i);

    if (error_count == 0 && dates_in_flight.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
